[sv/pairwise_attraction_force_core_assert.svh]
// ----------------------------------------------------------------------------
// pairwise_attraction_force_core_assert: assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef PAIRWISE_ATTRACTION_FORCE_CORE_ASSERT_SVH
`define PAIRWISE_ATTRACTION_FORCE_CORE_ASSERT_SVH

// same-cycle implication
`define PAFC_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PAFC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/pafc_pkg.sv]
// ----------------------------------------------------------------------------
// pafc_pkg: shared types and constants
// Widths of the force datapath, register indexes and the transfer structs.
// ----------------------------------------------------------------------------
package pafc_pkg;

   localparam int POS_W    = 32;
   localparam int MASS_W   = 32;
   localparam int MAG_W    = 32;
   localparam int SQ_W     = 66;
   localparam int ROOT_W   = 33;
   localparam int PROD_W   = 96;
   localparam int DEN_W    = 99;
   localparam int NUM_W    = 128;
   localparam int QUO_W    = 49;
   localparam int FORCE_W  = 48;
   localparam int CMP_W    = DEN_W + QUO_W;
   localparam int TRY_W    = SQ_W + 2;
   localparam int D_CHUNK  = 22;
   localparam int P_CHUNK  = 32;
   localparam int SQ_STAGES  = ROOT_W;
   localparam int DIV_STAGES = QUO_W;

   localparam int QDEPTH = 2;
   localparam int QPTR_W = 1;
   localparam int QCNT_W = 2;

   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_MIN_DIST = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_ENABLED  = 2'd2;

   localparam logic [POS_W-1:0]  STRENGTH_RST = 32'h0001_0000;
   localparam logic [MASS_W-1:0] MIN_DIST_RST = 32'h0001_0000;

   localparam logic [FORCE_W-1:0] FORCE_POS_LIM = {1'b0, {(FORCE_W-1){1'b1}}};
   localparam logic [FORCE_W-1:0] FORCE_NEG_LIM = {1'b1, {(FORCE_W-1){1'b0}}};

   typedef struct packed {
      logic [POS_W-1:0]  strength;
      logic [MASS_W-1:0] min_distance;
      logic              enabled;
   } cfg_type;

   typedef struct packed {
      logic [2:0][POS_W-1:0] a_pos;
      logic [2:0][POS_W-1:0] b_pos;
      logic [MASS_W-1:0]     a_mass;
      logic [MASS_W-1:0]     b_mass;
      logic                  a_free;
      logic                  b_free;
      logic                  b_present;
   } req_type;

   typedef struct packed {
      logic [2:0][MAG_W-1:0] mag;
      logic [2:0]            neg;
      logic [POS_W-1:0]      str_mag;
      logic [MASS_W-1:0]     a_mass;
      logic [MASS_W-1:0]     b_mass;
      logic                  a_free;
      logic                  b_free;
      logic                  kill;
   } work_type;

   typedef struct packed {
      logic [2:0][FORCE_W-1:0] a_force;
      logic [2:0][FORCE_W-1:0] b_force;
      logic                    a_apply;
      logic                    b_apply;
      logic                    saturated;
   } rsp_type;

endpackage

[sv/pairwise_attraction_force_core.sv]
// ----------------------------------------------------------------------------
// pairwise_attraction_force_core: inverse-square force between two particles
// Throughput: one pair per cycle unless the response side stalls, through the 33-stage square root and 49-stage divide.
// Sync active-high reset empties the pipe; strength 1.0, min distance 1.0, enabled.
// ----------------------------------------------------------------------------
module pairwise_attraction_force_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [pafc_pkg::CSR_ADDR_W-1:0]       csr_addr,
   input  logic [pafc_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [pafc_pkg::POS_W-1:0]     req_a_pos_x,
   input  logic signed [pafc_pkg::POS_W-1:0]     req_a_pos_y,
   input  logic signed [pafc_pkg::POS_W-1:0]     req_a_pos_z,
   input  logic signed [pafc_pkg::POS_W-1:0]     req_b_pos_x,
   input  logic signed [pafc_pkg::POS_W-1:0]     req_b_pos_y,
   input  logic signed [pafc_pkg::POS_W-1:0]     req_b_pos_z,
   input  logic [pafc_pkg::MASS_W-1:0]           req_a_mass,
   input  logic [pafc_pkg::MASS_W-1:0]           req_b_mass,
   input  logic                                  req_a_free,
   input  logic                                  req_b_free,
   input  logic                                  req_b_present,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [pafc_pkg::FORCE_W-1:0]   rsp_a_force_x,
   output logic signed [pafc_pkg::FORCE_W-1:0]   rsp_a_force_y,
   output logic signed [pafc_pkg::FORCE_W-1:0]   rsp_a_force_z,
   output logic signed [pafc_pkg::FORCE_W-1:0]   rsp_b_force_x,
   output logic signed [pafc_pkg::FORCE_W-1:0]   rsp_b_force_y,
   output logic signed [pafc_pkg::FORCE_W-1:0]   rsp_b_force_z,
   output logic                                  rsp_a_apply,
   output logic                                  rsp_b_apply,
   output logic                                  rsp_saturated
);
   import pafc_pkg::*;

   logic [POS_W-1:0]  strength_ff;
   logic [MASS_W-1:0] min_dist_ff;
   logic              enabled_ff;
   cfg_type           cfg;
   req_type           req;
   logic              f_valid;
   logic              f_ready;
   work_type          f_item;
   logic              q_valid;
   logic              q_ready;
   work_type          q_item;
   rsp_type           rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         strength_ff <= STRENGTH_RST;
         min_dist_ff <= MIN_DIST_RST;
         enabled_ff  <= 1'b1;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_STRENGTH: begin
               strength_ff <= csr_wdata;
            end
            CSR_MIN_DIST: begin
               min_dist_ff <= csr_wdata;
            end
            CSR_ENABLED: begin
               enabled_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.strength     = strength_ff;
   assign cfg.min_distance = min_dist_ff;
   assign cfg.enabled      = enabled_ff;

   assign req.a_pos[0]  = req_a_pos_x;
   assign req.a_pos[1]  = req_a_pos_y;
   assign req.a_pos[2]  = req_a_pos_z;
   assign req.b_pos[0]  = req_b_pos_x;
   assign req.b_pos[1]  = req_b_pos_y;
   assign req.b_pos[2]  = req_b_pos_z;
   assign req.a_mass    = req_a_mass;
   assign req.b_mass    = req_b_mass;
   assign req.a_free    = req_a_free;
   assign req.b_free    = req_b_free;
   assign req.b_present = req_b_present;

   pafc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req       (req),
      .out_valid (f_valid),
      .out_ready (f_ready),
      .out_item  (f_item)
   );

   pafc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (f_valid),
      .in_ready  (f_ready),
      .in_item   (f_item),
      .out_valid (q_valid),
      .out_ready (q_ready),
      .out_item  (q_item)
   );

   pafc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (q_valid),
      .in_ready  (q_ready),
      .in_item   (q_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   assign rsp_a_force_x = rsp.a_force[0];
   assign rsp_a_force_y = rsp.a_force[1];
   assign rsp_a_force_z = rsp.a_force[2];
   assign rsp_b_force_x = rsp.b_force[0];
   assign rsp_b_force_y = rsp.b_force[1];
   assign rsp_b_force_z = rsp.b_force[2];
   assign rsp_a_apply   = rsp.a_apply;
   assign rsp_b_apply   = rsp.b_apply;
   assign rsp_saturated = rsp.saturated;

endmodule

[sv/pafc_front.sv]
// ----------------------------------------------------------------------------
// pafc_front: request intake
// Takes a particle pair, forms per-axis distance magnitude and force sign,
// and flags pairs that produce no force.
// ----------------------------------------------------------------------------
module pafc_front (
   input  logic               clock,
   input  logic               reset,
   input  pafc_pkg::cfg_type  cfg,
   input  logic               req_valid,
   output logic               req_ready,
   input  pafc_pkg::req_type  req,
   output logic               out_valid,
   input  logic               out_ready,
   output pafc_pkg::work_type out_item
);
   import pafc_pkg::*;

   logic                  f_valid_ff;
   logic                  f_valid_in;
   work_type              item_ff;
   work_type              item_in;
   logic [2:0][POS_W:0]   diff;
   logic [2:0][POS_W:0]   diff_neg;
   logic [POS_W-1:0]      str_neg;

   assign req_ready = !f_valid_ff || out_ready;
   assign out_valid = f_valid_ff;
   assign out_item  = item_ff;

   always_comb begin
      str_neg = -cfg.strength;
      item_in.str_mag = cfg.strength[POS_W-1] ? str_neg : cfg.strength;
      item_in.a_mass  = req.a_mass;
      item_in.b_mass  = req.b_mass;
      item_in.a_free  = req.a_free;
      item_in.b_free  = req.b_free;
      item_in.kill    = !cfg.enabled || !req.b_present || !(req.a_free || req.b_free);
      for (int i = 0; i < 3; i++) begin
         diff[i] = {req.a_pos[i][POS_W-1], req.a_pos[i]} - {req.b_pos[i][POS_W-1], req.b_pos[i]};
         diff_neg[i] = -diff[i];
         item_in.mag[i] = diff[i][POS_W] ? diff_neg[i][MAG_W-1:0] : diff[i][MAG_W-1:0];
         item_in.neg[i] = cfg.strength[POS_W-1] ^ diff[i][POS_W];
      end
      f_valid_in = (req_valid && req_ready) || (f_valid_ff && !out_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
   end

endmodule

[sv/pafc_queue.sv]
// ----------------------------------------------------------------------------
// pafc_queue: two-entry queue between intake and force pipeline
// Registered ready on the intake side; head is read directly.
// ----------------------------------------------------------------------------
module pafc_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  pafc_pkg::work_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output pafc_pkg::work_type out_item
);
   import pafc_pkg::*;

   logic [QCNT_W-1:0] cnt_ff;
   logic [QPTR_W-1:0] wr_ptr_ff;
   logic [QPTR_W-1:0] rd_ptr_ff;
   work_type          mem_ff [QDEPTH];
   logic              push;
   logic              pop;

   assign in_ready  = cnt_ff != QCNT_W'(QDEPTH);
   assign out_valid = cnt_ff != '0;
   assign out_item  = mem_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         cnt_ff <= cnt_ff + QCNT_W'(push) - QCNT_W'(pop);
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

[sv/pafc_back.sv]
// ----------------------------------------------------------------------------
// pafc_back: force pipeline
// Squared distance with clamp, pipelined square root, numerator and
// denominator products, pipelined restoring divide and saturation.
// The whole pipe advances together while the output slot is free.
// ----------------------------------------------------------------------------
`include "pairwise_attraction_force_core_assert.svh"

module pafc_back (
   input  logic               clock,
   input  logic               reset,
   input  pafc_pkg::cfg_type  cfg,
   input  logic               in_valid,
   output logic               in_ready,
   input  pafc_pkg::work_type in_item,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output pafc_pkg::rsp_type  rsp
);
   import pafc_pkg::*;

   localparam int NSTG = 3 + SQ_STAGES + 3 + DIV_STAGES + 1;

   typedef struct packed {
      logic [2:0] neg;
      logic       a_free;
      logic       b_free;
      logic       kill;
      logic       zero;
   } ctl_type;

   logic                  adv;
   logic [NSTG-1:0]       vld_ff;

   // squares and mass product
   logic [2:0][63:0]      sq_ff;
   logic [63:0]           m2_ff;
   logic [62:0]           km_ff;
   logic [MASS_W-1:0]     mb_ff;
   logic [2:0][MAG_W-1:0] mag1_ff;
   ctl_type               ctl1_ff;
   ctl_type               ctl1_in;

   logic [SQ_W-1:0]       d2raw_ff;
   logic [63:0]           pl_ff;
   logic [62:0]           ph_ff;
   logic [63:0]           m2b_ff;
   logic [2:0][MAG_W-1:0] mag2_ff;
   ctl_type               ctl2_ff;
   ctl_type               ctl3_in;

   // square root
   logic [SQ_W-1:0]       sr_rem_ff  [0:SQ_STAGES];
   logic [ROOT_W-1:0]     sr_root_ff [0:SQ_STAGES];
   logic [SQ_W-1:0]       sr_d2_ff   [0:SQ_STAGES];
   logic [PROD_W-1:0]     sr_p_ff    [0:SQ_STAGES];
   logic [2:0][MAG_W-1:0] sr_mag_ff  [0:SQ_STAGES];
   ctl_type               sr_ctl_ff  [0:SQ_STAGES];
   logic [TRY_W-1:0]      sr_try     [SQ_STAGES];
   logic                  sr_take    [SQ_STAGES];
   logic [SQ_W-1:0]       sr_rem_in  [SQ_STAGES];
   logic [ROOT_W-1:0]     sr_root_in [SQ_STAGES];

   // products
   logic [2:0][54:0]          dp_ff;
   logic [2:0][2:0][63:0]     np_ff;
   ctl_type                   mc1_ff;
   logic [DEN_W-1:0]          den_ff;
   logic [2:0][NUM_W-1:0]     num_ff;
   ctl_type                   mc2_ff;

   // divide
   logic [2:0][NUM_W-1:0] dv_rem_ff [0:DIV_STAGES];
   logic [2:0][QUO_W-1:0] dv_q_ff   [0:DIV_STAGES];
   logic [2:0]            dv_ovf_ff [0:DIV_STAGES];
   logic [DEN_W-1:0]      dv_den_ff [0:DIV_STAGES];
   ctl_type               dv_ctl_ff [0:DIV_STAGES];
   logic [CMP_W-1:0]      dv_sh     [DIV_STAGES];
   logic [2:0]            dv_take   [DIV_STAGES];
   logic [2:0][NUM_W-1:0] dv_rem_in [DIV_STAGES];
   logic [2:0][QUO_W-1:0] dv_q_in   [DIV_STAGES];

   // output
   rsp_type               out_ff;
   rsp_type               out_in;
   logic [2:0][FORCE_W:0] sat_a;
   logic [2:0][FORCE_W:0] sat_b;
   ctl_type               oc;

   function automatic logic [FORCE_W:0] sat_force(input logic [QUO_W-1:0] q,
                                                  input logic ovf, input logic neg);
      logic [FORCE_W-1:0] lim;
      logic [FORCE_W-1:0] m;
      logic [FORCE_W-1:0] m_neg;
      logic               clip;
      lim   = neg ? FORCE_NEG_LIM : FORCE_POS_LIM;
      clip  = ovf || (q > QUO_W'(lim));
      m     = clip ? lim : q[FORCE_W-1:0];
      m_neg = -m;
      return {clip, neg ? m_neg : m};
   endfunction

   assign adv       = !vld_ff[NSTG-1] || rsp_ready;
   assign in_ready  = adv;
   assign rsp_valid = vld_ff[NSTG-1];
   assign rsp       = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_comb begin
      ctl1_in.neg    = in_item.neg;
      ctl1_in.a_free = in_item.a_free;
      ctl1_in.b_free = in_item.b_free;
      ctl1_in.kill   = in_item.kill;
      ctl1_in.zero   = 1'b0;
      ctl3_in        = ctl2_ff;
      ctl3_in.zero   = (d2raw_ff == '0) && (m2b_ff == '0);
   end

   always_comb begin
      for (int s = 0; s < SQ_STAGES; s++) begin
         sr_try[s]  = (TRY_W'(sr_root_ff[s]) << (ROOT_W - s))
                    | (TRY_W'(1) << (2 * (ROOT_W - 1 - s)));
         sr_take[s] = TRY_W'(sr_rem_ff[s]) >= sr_try[s];
         sr_rem_in[s]  = sr_take[s] ? sr_rem_ff[s] - sr_try[s][SQ_W-1:0] : sr_rem_ff[s];
         sr_root_in[s] = sr_take[s] ? sr_root_ff[s] | (ROOT_W'(1) << (ROOT_W - 1 - s))
                                    : sr_root_ff[s];
      end
   end

   always_comb begin
      for (int s = 0; s < DIV_STAGES; s++) begin
         dv_sh[s] = CMP_W'(dv_den_ff[s]) << (QUO_W - 1 - s);
         for (int i = 0; i < 3; i++) begin
            dv_take[s][i]   = CMP_W'(dv_rem_ff[s][i]) >= dv_sh[s];
            dv_rem_in[s][i] = dv_take[s][i] ? dv_rem_ff[s][i] - dv_sh[s][NUM_W-1:0]
                                            : dv_rem_ff[s][i];
            dv_q_in[s][i]   = dv_take[s][i] ? dv_q_ff[s][i] | (QUO_W'(1) << (QUO_W - 1 - s))
                                            : dv_q_ff[s][i];
         end
      end
   end

   always_comb begin
      oc     = dv_ctl_ff[DIV_STAGES];
      out_in = '0;
      for (int i = 0; i < 3; i++) begin
         sat_a[i] = sat_force(dv_q_ff[DIV_STAGES][i], dv_ovf_ff[DIV_STAGES][i], !oc.neg[i]);
         sat_b[i] = sat_force(dv_q_ff[DIV_STAGES][i], dv_ovf_ff[DIV_STAGES][i], oc.neg[i]);
      end
      if (!oc.kill && !oc.zero) begin
         out_in.a_apply = oc.a_free;
         out_in.b_apply = oc.b_free;
         for (int i = 0; i < 3; i++) begin
            if (oc.a_free) begin
               out_in.a_force[i] = sat_a[i][FORCE_W-1:0];
               out_in.saturated  = out_in.saturated | sat_a[i][FORCE_W];
            end
            if (oc.b_free) begin
               out_in.b_force[i] = sat_b[i][FORCE_W-1:0];
               out_in.saturated  = out_in.saturated | sat_b[i][FORCE_W];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 64'(in_item.mag[i]) * 64'(in_item.mag[i]);
         end
         m2_ff   <= 64'(cfg.min_distance) * 64'(cfg.min_distance);
         km_ff   <= 63'(64'(in_item.str_mag) * 64'(in_item.a_mass));
         mb_ff   <= in_item.b_mass;
         mag1_ff <= in_item.mag;
         ctl1_ff <= ctl1_in;

         d2raw_ff <= SQ_W'(sq_ff[0]) + SQ_W'(sq_ff[1]) + SQ_W'(sq_ff[2]);
         pl_ff    <= 64'(km_ff[31:0]) * 64'(mb_ff);
         ph_ff    <= 63'(km_ff[62:32]) * 63'(mb_ff);
         m2b_ff   <= m2_ff;
         mag2_ff  <= mag1_ff;
         ctl2_ff  <= ctl1_ff;

         sr_d2_ff[0]   <= (d2raw_ff >= SQ_W'(m2b_ff)) ? d2raw_ff : SQ_W'(m2b_ff);
         sr_rem_ff[0]  <= (d2raw_ff >= SQ_W'(m2b_ff)) ? d2raw_ff : SQ_W'(m2b_ff);
         sr_root_ff[0] <= '0;
         sr_p_ff[0]    <= PROD_W'(pl_ff) + (PROD_W'(ph_ff) << P_CHUNK);
         sr_mag_ff[0]  <= mag2_ff;
         sr_ctl_ff[0]  <= ctl3_in;
         for (int s = 0; s < SQ_STAGES; s++) begin
            sr_rem_ff[s+1]  <= sr_rem_in[s];
            sr_root_ff[s+1] <= sr_root_in[s];
            sr_d2_ff[s+1]   <= sr_d2_ff[s];
            sr_p_ff[s+1]    <= sr_p_ff[s];
            sr_mag_ff[s+1]  <= sr_mag_ff[s];
            sr_ctl_ff[s+1]  <= sr_ctl_ff[s];
         end

         for (int c = 0; c < 3; c++) begin
            dp_ff[c] <= 55'(sr_d2_ff[SQ_STAGES][D_CHUNK*c +: D_CHUNK])
                      * 55'(sr_root_ff[SQ_STAGES]);
            for (int i = 0; i < 3; i++) begin
               np_ff[i][c] <= 64'(sr_p_ff[SQ_STAGES][P_CHUNK*c +: P_CHUNK])
                            * 64'(sr_mag_ff[SQ_STAGES][i]);
            end
         end
         mc1_ff <= sr_ctl_ff[SQ_STAGES];

         den_ff <= DEN_W'(dp_ff[0]) + (DEN_W'(dp_ff[1]) << D_CHUNK)
                 + (DEN_W'(dp_ff[2]) << (2 * D_CHUNK));
         for (int i = 0; i < 3; i++) begin
            num_ff[i] <= NUM_W'(np_ff[i][0]) + (NUM_W'(np_ff[i][1]) << P_CHUNK)
                       + (NUM_W'(np_ff[i][2]) << (2 * P_CHUNK));
         end
         mc2_ff <= mc1_ff;

         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= num_ff[i];
            dv_q_ff[0][i]   <= '0;
            dv_ovf_ff[0][i] <= CMP_W'(num_ff[i]) >= (CMP_W'(den_ff) << QUO_W);
         end
         dv_den_ff[0] <= den_ff;
         dv_ctl_ff[0] <= mc2_ff;
         for (int s = 0; s < DIV_STAGES; s++) begin
            dv_rem_ff[s+1] <= dv_rem_in[s];
            dv_q_ff[s+1]   <= dv_q_in[s];
            dv_ovf_ff[s+1] <= dv_ovf_ff[s];
            dv_den_ff[s+1] <= dv_den_ff[s];
            dv_ctl_ff[s+1] <= dv_ctl_ff[s];
         end

         out_ff <= out_in;
      end
   end

   `PAFC_ASSERT_NEXT(a_stall_holds_pipe, vld_ff[NSTG-1] && !rsp_ready, vld_ff == $past(vld_ff), "pipeline moved while output stalled")
   `PAFC_ASSERT_IMPL(a_no_apply_no_force, vld_ff[NSTG-1] && !out_ff.a_apply, out_ff.a_force == '0, "force on A without apply")
   `PAFC_ASSERT_IMPL(a_sat_needs_apply, vld_ff[NSTG-1] && out_ff.saturated, out_ff.a_apply || out_ff.b_apply, "saturation flagged with no applied force")

endmodule

[sim/pairwise_attraction_force_core_tb.sv]
// ----------------------------------------------------------------------------
// pairwise_attraction_force_core_tb: self-checking bench for the force core
// Drives particle pairs through the valid/ready request port, computes the
// expected saturated forces with a wide-integer model of the Q16.16 math, and
// compares every response transfer field by field. Runs a directed table,
// then random pairs over several register settings with random idling on
// both sides and one long response hold-off.
// ----------------------------------------------------------------------------
module pairwise_attraction_force_core_tb;
   import pafc_pkg::*;

   typedef struct {
      req_type pair;
      bit      known;
      rsp_type force_exp;
   } pair_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_pair = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [FORCE_W-1:0] rsp_a_force_x, rsp_a_force_y, rsp_a_force_z;
   logic signed [FORCE_W-1:0] rsp_b_force_x, rsp_b_force_y, rsp_b_force_z;
   logic rsp_a_apply, rsp_b_apply, rsp_saturated;

   cfg_type   cfg_model;
   rsp_type   forces_due[$];
   pair_row_type pair_table[$];
   int        error_count = 0;
   int        pairs_sent = 0;
   int        forces_seen = 0;
   int        clipped_seen = 0;
   bit        calm = 1'b0;
   int        hold_off = 0;

   always #5 clock = ~clock;

   pairwise_attraction_force_core dut (
      .clock(clock), .reset(reset),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_a_pos_x(req_pair.a_pos[0]), .req_a_pos_y(req_pair.a_pos[1]),
      .req_a_pos_z(req_pair.a_pos[2]),
      .req_b_pos_x(req_pair.b_pos[0]), .req_b_pos_y(req_pair.b_pos[1]),
      .req_b_pos_z(req_pair.b_pos[2]),
      .req_a_mass(req_pair.a_mass), .req_b_mass(req_pair.b_mass),
      .req_a_free(req_pair.a_free), .req_b_free(req_pair.b_free),
      .req_b_present(req_pair.b_present),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_a_force_x(rsp_a_force_x), .rsp_a_force_y(rsp_a_force_y),
      .rsp_a_force_z(rsp_a_force_z),
      .rsp_b_force_x(rsp_b_force_x), .rsp_b_force_y(rsp_b_force_y),
      .rsp_b_force_z(rsp_b_force_z),
      .rsp_a_apply(rsp_a_apply), .rsp_b_apply(rsp_b_apply),
      .rsp_saturated(rsp_saturated)
   );

   function automatic logic [FORCE_W-1:0] clip_force(input logic [127:0] q, input bit neg,
                                                     output bit hit);
      logic [127:0] lim;
      logic [127:0] m;
      lim = neg ? 128'(FORCE_NEG_LIM) : 128'(FORCE_POS_LIM);
      m = q;
      hit = 1'b0;
      if (q > lim) begin
         m = lim;
         hit = 1'b1;
      end
      return neg ? FORCE_W'(-m) : FORCE_W'(m);
   endfunction

   function automatic rsp_type attraction_forces(input cfg_type c, input req_type r);
      rsp_type res;
      logic signed [33:0] d [3];
      logic [32:0] u [3];
      logic [67:0] d2, m2;
      logic [69:0] root, trial;
      logic [127:0] den, p, q;
      logic [31:0] kmag;
      bit kneg, neg, hit;
      res = '0;
      if (!c.enabled || !r.b_present || !(r.a_free || r.b_free)) return res;
      for (int i = 0; i < 3; i++) begin
         d[i] = 34'(signed'(r.a_pos[i])) - 34'(signed'(r.b_pos[i]));
         u[i] = d[i] < 0 ? 33'(-d[i]) : 33'(d[i]);
      end
      d2 = 68'(u[0]) * 68'(u[0]) + 68'(u[1]) * 68'(u[1]) + 68'(u[2]) * 68'(u[2]);
      m2 = 68'(c.min_distance) * 68'(c.min_distance);
      if (d2 < m2) d2 = m2;
      if (d2 == 0) return res;
      root = '0;
      for (int i = 34; i >= 0; i--) begin
         trial = root | (70'd1 << i);
         if (140'(trial) * 140'(trial) <= 140'(d2)) root = trial;
      end
      den = 128'(d2) * 128'(root);
      kneg = c.strength[31];
      kmag = kneg ? -c.strength : c.strength;
      p = 128'(kmag) * 128'(r.a_mass) * 128'(r.b_mass);
      for (int i = 0; i < 3; i++) begin
         q = (p * 128'(u[i])) / den;
         neg = kneg != (d[i] < 0);
         if (r.a_free) begin
            res.a_force[i] = clip_force(q, !neg, hit);
            res.saturated |= hit;
         end
         if (r.b_free) begin
            res.b_force[i] = clip_force(q, neg, hit);
            res.saturated |= hit;
         end
      end
      res.a_apply = r.a_free;
      res.b_apply = r.b_free;
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [FORCE_W-1:0] got,
                                  input logic [FORCE_W-1:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
      error_count++;
   endtask

   task automatic check_field(input string what, input logic [FORCE_W-1:0] got,
                              input logic [FORCE_W-1:0] want);
      if (got !== want) report_mismatch(what, got, want);
   endtask

   // response side: check transfers, randomize ready
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (forces_due.size() == 0) begin
            report_mismatch("unexpected response", '0, '0);
         end else begin
            want = forces_due.pop_front();
            forces_seen++;
            if (rsp_saturated) clipped_seen++;
            check_field("a_force_x", rsp_a_force_x, want.a_force[0]);
            check_field("a_force_y", rsp_a_force_y, want.a_force[1]);
            check_field("a_force_z", rsp_a_force_z, want.a_force[2]);
            check_field("b_force_x", rsp_b_force_x, want.b_force[0]);
            check_field("b_force_y", rsp_b_force_y, want.b_force[1]);
            check_field("b_force_z", rsp_b_force_z, want.b_force[2]);
            check_field("a_apply", FORCE_W'(rsp_a_apply), FORCE_W'(want.a_apply));
            check_field("b_apply", FORCE_W'(rsp_b_apply), FORCE_W'(want.b_apply));
            check_field("saturated", FORCE_W'(rsp_saturated), FORCE_W'(want.saturated));
         end
      end
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= calm || ($urandom_range(99) >= 13);
      end
   end

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [31:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_STRENGTH: cfg_model.strength = val;
         CSR_MIN_DIST: cfg_model.min_distance = val;
         CSR_ENABLED:  cfg_model.enabled = val[0];
         default: ;
      endcase
   endtask

   task automatic drain;
      while (forces_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic set_regs(input logic [31:0] k, input logic [31:0] dmin, input bit on);
      drain();
      write_reg(CSR_STRENGTH, k);
      write_reg(CSR_MIN_DIST, dmin);
      write_reg(CSR_ENABLED, {31'd0, on});
   endtask

   task automatic send_pair(input req_type r);
      if (!calm && $urandom_range(99) < 4) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_pair <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      forces_due.push_back(attraction_forces(cfg_model, r));
      pairs_sent++;
   endtask

   function automatic logic [31:0] rand_coord;
      case ($urandom_range(3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
         2: return 32'($signed($urandom_range(0, 1 << 17)) - (1 << 16));
         default: return $urandom_range(0, 3) == 0 ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   function automatic req_type rand_pair;
      req_type r;
      for (int i = 0; i < 3; i++) begin
         r.a_pos[i] = rand_coord();
         r.b_pos[i] = ($urandom_range(9) == 0) ? r.a_pos[i] : rand_coord();
      end
      r.a_mass = $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 18);
      r.b_mass = $urandom_range(1) ? $urandom : $urandom_range(0, 1 << 18);
      r.a_free = 1'($urandom_range(1));
      r.b_free = 1'($urandom_range(1));
      r.b_present = $urandom_range(7) != 0;
      return r;
   endfunction

   function automatic req_type make_pair(input logic [31:0] ax, input logic [31:0] bx,
                                         input logic [31:0] ma, input logic [31:0] mb,
                                         input bit af, input bit bf, input bit bp);
      req_type r;
      r = '0;
      r.a_pos[0] = ax;
      r.b_pos[0] = bx;
      r.a_pos[1] = 32'h0003_0000;
      r.b_pos[1] = 32'hfffe_0000;
      r.a_mass = ma;
      r.b_mass = mb;
      r.a_free = af;
      r.b_free = bf;
      r.b_present = bp;
      return r;
   endfunction

   task automatic add_row(input req_type r, input bit known, input rsp_type f);
      pair_row_type row;
      row.pair = r;
      row.known = known;
      row.force_exp = f;
      pair_table.push_back(row);
   endtask

   task automatic run_random(input int count);
      repeat (count) send_pair(rand_pair());
      req_valid <= 1'b0;
   endtask

   initial begin
      rsp_type zero_force, still;
      req_type r;
      cfg_model.strength = STRENGTH_RST;
      cfg_model.min_distance = MIN_DIST_RST;
      cfg_model.enabled = 1'b1;
      zero_force = '0;
      still = '0;
      still.a_apply = 1'b1;
      still.b_apply = 1'b1;

      add_row(make_pair(32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000, 1, 1, 0), 1, zero_force);
      add_row(make_pair(32'h0001_0000, 0, 32'h0001_0000, 32'h0001_0000, 0, 0, 1), 1, zero_force);
      r = make_pair(32'h0004_0000, 32'h0004_0000, 32'h0002_0000, 32'h0002_0000, 1, 1, 1);
      r.b_pos[1] = r.a_pos[1];
      add_row(r, 1, still);
      add_row(make_pair(32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1),
              0, zero_force);
      add_row(make_pair(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 0, 1),
              0, zero_force);
      add_row(make_pair(32'h0000_8000, 0, 32'h0010_0000, 32'h0010_0000, 0, 1, 1), 0, zero_force);
      add_row(make_pair(32'h0002_0000, 32'hfffe_0000, 0, 32'hffff_ffff, 1, 1, 1), 0, zero_force);
      add_row(make_pair(32'h0000_0001, 0, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1), 0, zero_force);
      add_row(make_pair(32'h1234_5678, 32'hedcb_a987, 32'h0003_0000, 32'h0005_0000, 1, 1, 1),
              0, zero_force);
      add_row(make_pair(32'h0100_0000, 0, 32'h0001_0000, 32'h0001_0000, 1, 1, 1), 0, zero_force);

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      calm = 1'b1;
      foreach (pair_table[i]) begin
         send_pair(pair_table[i].pair);
         if (pair_table[i].known) forces_due[$] = pair_table[i].force_exp;
      end
      req_valid <= 1'b0;
      calm = 1'b0;

      set_regs(32'h8000_0000, 32'h0000_0000, 1'b1);
      r = make_pair(32'h0005_0000, 32'h0005_0000, 32'h0001_0000, 32'h0001_0000, 1, 1, 1);
      r.b_pos[1] = r.a_pos[1];
      send_pair(r);
      forces_due[$] = zero_force;
      run_random(190);

      set_regs(32'h7fff_ffff, 32'hffff_ffff, 1'b1);
      calm = 1'b1;
      hold_off = 400;
      run_random(190);
      calm = 1'b0;

      set_regs(32'h0000_0000, 32'h0000_0100, 1'b1);
      run_random(120);

      set_regs(32'h0001_0000, 32'h0001_0000, 1'b0);
      run_random(120);

      set_regs(32'hfff0_0000, 32'h0000_4000, 1'b1);
      run_random(250);

      set_regs($urandom, $urandom_range(0, 1 << 17), 1'b1);
      run_random(270);

      while (forces_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("Checked %0d pairs (%0d with clipped forces) over seven register settings,",
               forces_seen, clipped_seen);
      $display("including repel, zero minimum distance, disabled and a long response stall.");
      if (error_count == 0 && forces_seen == pairs_sent) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #8000000;
      $display("Timeout with %0d responses outstanding", forces_due.size());
      $display("Simulation FAILED");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/pafc_pkg.sv
sv/pafc_front.sv
sv/pafc_queue.sv
sv/pafc_back.sv
sv/pairwise_attraction_force_core.sv
sim/pairwise_attraction_force_core_tb.sv
